FILE: src/wps_pkg.sv
// Shared types and constants of the WAV/PCM stream parser.
// Used by every module under src except wps_fifo; depends on nothing else.
package wps_pkg;

   // Default sizes handed down from the top level.
   localparam int SAMPLE_OUT_WIDTH_DEF = 16;
   localparam int CMD_DEPTH_DEF        = 4;
   localparam int RSP_DEPTH_DEF        = 4;

   // Four-character tags as they read in little-endian order.
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_CHUNK_BYTES = 32'd16;
   localparam logic [15:0] FMT_TAG_PCM     = 16'd1;

   // Result kinds.
   localparam logic [1:0] KIND_FORMAT   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE   = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;
   localparam logic [1:0] KIND_DATA_END = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_NOT_RIFF    = 2'd1;
   localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ERR_DATA_FIRST  = 2'd3;

   typedef enum logic [3:0] {
      PH_TAG_RIFF,
      PH_LEN_RIFF,
      PH_TAG_WAVE,
      PH_CHUNK_ID,
      PH_FMT_LEN,
      PH_FMT_BODY,
      PH_DATA_LEN,
      PH_DATA_BODY,
      PH_END_PENDING,
      PH_STOPPED
   } phase_type;

   // One classified result, handed from the parser to the sample converter.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] sample_raw;   // 8-bit samples sit in the low byte
      logic        wide;         // sample is 16-bit
      logic        chan;
      logic [1:0]  chans;
      logic [31:0] rate;
      logic [4:0]  bits;
      logic [1:0]  err;
   } cmd_type;

   localparam int CMD_WIDTH = $bits(cmd_type);

endpackage

FILE: src/wav_pcm_stream_parser.sv
// Top level of the WAV/PCM stream parser: parser front end, command queue,
// sample converter and result queue. Depends on wps_pkg and all wps_ modules.
//
//   channel   ports                              flow control
//   -------   --------------------------------   ----------------------------------
//   bytes in  req_in_byte                        push / full, taken when full low
//   results   rsp_kind .. rsp_error_code (7)     empty / pop, oldest result shown
//
// The block takes one file byte in every cycle while full is low. Each byte is
// classified by the front end in the cycle it is accepted; a result passes the
// command queue and the two converter stages to the result queue and shows on
// the ports while empty is low. The two-stage divide-by-255 path serves 8-bit
// samples; throughput is one byte a cycle while full is low. Reset clears the
// parse state and both queues. When results are not popped, the result queue,
// the converter stages and then the command queue fill, and only then does
// full rise to hold back the byte stream.
module wav_pcm_stream_parser #(
   parameter int SAMPLE_OUT_WIDTH = wps_pkg::SAMPLE_OUT_WIDTH_DEF,
   parameter int CMD_DEPTH        = wps_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH        = wps_pkg::RSP_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Byte stream.
   input  logic [7:0]                         req_in_byte,
   input  logic                               push,
   output logic                               full,
   // Results.
   output logic [1:0]                         rsp_kind,
   output logic signed [SAMPLE_OUT_WIDTH-1:0] rsp_sample_value,
   output logic                               rsp_channel_index,
   output logic [1:0]                         rsp_channel_count,
   output logic [31:0]                        rsp_sample_rate,
   output logic [4:0]                         rsp_sample_bits,
   output logic [1:0]                         rsp_error_code,
   output logic                               empty,
   input  logic                               pop
);

   import wps_pkg::*;

   localparam int OW = SAMPLE_OUT_WIDTH + 44;

   // Front end to command queue.
   logic           byte_accept;
   logic           cmd_push;
   cmd_type        cmd_wr;
   logic           cmd_full;

   // Command queue to converter.
   logic [CMD_WIDTH-1:0] cmd_rd_bits;
   cmd_type        cmd_rd;
   logic           cmd_empty;
   logic           cmd_pop;

   // Converter to result queue.
   logic [OW-1:0]  rsp_wr_data;
   logic           rsp_push;
   logic           rsp_full;
   logic [OW-1:0]  rsp_rd_data;

   // Every beat may produce a command, so the byte side stalls whenever the
   // command queue has no free slot.
   assign full        = cmd_full;
   assign byte_accept = push && !cmd_full;
   assign cmd_rd      = cmd_type'(cmd_rd_bits);

   wps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (byte_accept),
      .in_byte  (req_in_byte),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   wps_fifo #(
      .WIDTH (CMD_WIDTH),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_bits),
      .empty   (cmd_empty)
   );

   wps_back #(
      .SAMPLE_OUT_WIDTH (SAMPLE_OUT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .out_data  (rsp_wr_data),
      .out_push  (rsp_push),
      .out_full  (rsp_full)
   );

   wps_fifo #(
      .WIDTH (OW),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr_data),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_rd_data),
      .empty   (empty)
   );

   // The result word is packed by the converter in port order.
   assign {rsp_kind, rsp_sample_value, rsp_channel_index, rsp_channel_count,
           rsp_sample_rate, rsp_sample_bits, rsp_error_code} = rsp_rd_data;

endmodule

FILE: src/wps_fifo.sv
// Small first-word-fall-through queue built from a register array.
// Used between parser and converter and on the result side; no package use.
module wps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = push && !full;
   assign do_rd   = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: src/wps_front.sv
// Parser front end: walks the RIFF/WAVE structure one byte per cycle while
// in_valid is high and issues one command per result. Depends on wps_pkg.
module wps_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   output logic             cmd_push,
   output wps_pkg::cmd_type cmd
);

   import wps_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  fbc_ff, fbc_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] riff_len_ff, riff_len_in;
   logic [31:0] riff_pos_ff, riff_pos_in;
   logic [1:0]  fmt_ch_ff, fmt_ch_in;
   logic [31:0] fmt_rate_ff, fmt_rate_in;
   logic [4:0]  fmt_bits_ff, fmt_bits_in;
   logic [31:0] data_left_ff, data_left_in;
   logic        cur_ch_ff, cur_ch_in;
   logic [7:0]  low_ff, low_in;
   logic        fmt_found_ff, fmt_found_in;

   logic [31:0] gather_word;
   logic        gather_done;
   logic [31:0] pos_bumped;
   logic [2:0]  frame_bytes;
   logic        partial_frame;
   logic        have_sample;
   logic [15:0] fmt_bits_word;
   logic        emit;
   logic [1:0]  emit_kind;
   logic [1:0]  emit_err;
   logic [15:0] emit_raw;
   logic        emit_chan;

   always_comb begin
      phase_in     = phase_ff;
      fbc_in       = fbc_ff;
      asm_in       = asm_ff;
      riff_len_in  = riff_len_ff;
      riff_pos_in  = riff_pos_ff;
      fmt_ch_in    = fmt_ch_ff;
      fmt_rate_in  = fmt_rate_ff;
      fmt_bits_in  = fmt_bits_ff;
      data_left_in = data_left_ff;
      cur_ch_in    = cur_ch_ff;
      low_in       = low_ff;
      fmt_found_in = fmt_found_ff;

      emit      = 1'b0;
      emit_kind = KIND_FORMAT;
      emit_err  = ERR_NONE;
      emit_raw  = '0;
      emit_chan = 1'b0;

      gather_word   = asm_ff | ({24'd0, in_byte} << {fbc_ff[1:0], 3'b000});
      gather_done   = (fbc_ff[1:0] == 2'd3);
      pos_bumped    = (riff_pos_ff == '1) ? riff_pos_ff : riff_pos_ff + 32'd1;
      fmt_bits_word = {in_byte, low_ff};
      if (fmt_ch_ff == 2'd2) begin
         frame_bytes = fmt_bits_ff[4] ? 3'd4 : 3'd2;
      end else begin
         frame_bytes = fmt_bits_ff[4] ? 3'd2 : 3'd1;
      end
      partial_frame = !cur_ch_ff && (fbc_ff == '0) && (data_left_ff < {29'd0, frame_bytes});
      have_sample   = 1'b0;

      if (in_valid) begin
         unique case (phase_ff) inside
            PH_TAG_RIFF, PH_TAG_WAVE: begin
               asm_in = gather_word;
               fbc_in = fbc_ff + 5'd1;
               if (gather_done) begin
                  asm_in = '0;
                  fbc_in = '0;
                  if (gather_word != ((phase_ff == PH_TAG_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
                     phase_in  = PH_STOPPED;
                     emit      = 1'b1;
                     emit_kind = KIND_ERROR;
                     emit_err  = ERR_NOT_RIFF;
                  end else begin
                     phase_in = (phase_ff == PH_TAG_RIFF) ? PH_LEN_RIFF : PH_CHUNK_ID;
                  end
               end
            end
            PH_LEN_RIFF: begin
               asm_in = gather_word;
               fbc_in = fbc_ff + 5'd1;
               if (gather_done) begin
                  riff_len_in = gather_word;
                  asm_in      = '0;
                  fbc_in      = '0;
                  phase_in    = PH_TAG_WAVE;
               end
            end
            PH_CHUNK_ID, PH_END_PENDING: begin
               if ((fbc_ff == '0) && (riff_pos_ff >= riff_len_ff)) begin
                  phase_in = PH_STOPPED;
               end else begin
                  riff_pos_in = pos_bumped;
                  asm_in      = gather_word;
                  fbc_in      = fbc_ff + 5'd1;
                  phase_in    = PH_CHUNK_ID;
                  if (gather_done) begin
                     asm_in = '0;
                     fbc_in = '0;
                     if (gather_word == TAG_FMT) begin
                        phase_in = PH_FMT_LEN;
                     end else if (gather_word == TAG_DATA) begin
                        if (!fmt_found_ff) begin
                           phase_in  = PH_STOPPED;
                           emit      = 1'b1;
                           emit_kind = KIND_ERROR;
                           emit_err  = ERR_DATA_FIRST;
                        end else if ((fmt_ch_ff == '0) || (fmt_bits_ff == '0)) begin
                           phase_in  = PH_STOPPED;
                           emit      = 1'b1;
                           emit_kind = KIND_ERROR;
                           emit_err  = ERR_UNSUPPORTED;
                        end else begin
                           phase_in = PH_DATA_LEN;
                        end
                     end
                  end
               end
               // The byte after a data chunk that ended on a sample also closes it.
               if (phase_ff == PH_END_PENDING) begin
                  emit      = 1'b1;
                  emit_kind = KIND_DATA_END;
                  emit_err  = ERR_NONE;
               end
            end
            PH_FMT_LEN: begin
               riff_pos_in = pos_bumped;
               asm_in      = gather_word;
               fbc_in      = fbc_ff + 5'd1;
               if (gather_done) begin
                  asm_in = '0;
                  fbc_in = '0;
                  if (gather_word != FMT_CHUNK_BYTES) begin
                     phase_in  = PH_STOPPED;
                     emit      = 1'b1;
                     emit_kind = KIND_ERROR;
                     emit_err  = ERR_UNSUPPORTED;
                  end else begin
                     fmt_rate_in = '0;
                     phase_in    = PH_FMT_BODY;
                  end
               end
            end
            PH_FMT_BODY: begin
               riff_pos_in = pos_bumped;
               fbc_in      = fbc_ff + 5'd1;
               if (fbc_ff < 5'd4) begin
                  asm_in = gather_word;
               end else if (fbc_ff < 5'd8) begin
                  fmt_rate_in = fmt_rate_ff | ({24'd0, in_byte} << {fbc_ff[1:0], 3'b000});
               end else if (fbc_ff == 5'd14) begin
                  low_in = in_byte;
               end else if (fbc_ff >= 5'd15) begin
                  fbc_in = '0;
                  asm_in = '0;
                  if (asm_ff[15:0] != FMT_TAG_PCM) begin
                     phase_in  = PH_STOPPED;
                     emit      = 1'b1;
                     emit_kind = KIND_ERROR;
                     emit_err  = ERR_UNSUPPORTED;
                  end else begin
                     fmt_ch_in = ((asm_ff[31:16] == 16'd1) || (asm_ff[31:16] == 16'd2))
                                 ? asm_ff[17:16] : 2'd0;
                     fmt_bits_in = ((fmt_bits_word == 16'd8) || (fmt_bits_word == 16'd16))
                                   ? fmt_bits_word[4:0] : 5'd0;
                     fmt_found_in = 1'b1;
                     phase_in     = PH_CHUNK_ID;
                     emit         = 1'b1;
                     emit_kind    = KIND_FORMAT;
                  end
               end
            end
            PH_DATA_LEN: begin
               riff_pos_in = pos_bumped;
               asm_in      = gather_word;
               fbc_in      = fbc_ff + 5'd1;
               if (gather_done) begin
                  data_left_in = gather_word;
                  asm_in       = '0;
                  cur_ch_in    = 1'b0;
                  fbc_in       = '0;
                  if (gather_word == '0) begin
                     phase_in  = PH_CHUNK_ID;
                     emit      = 1'b1;
                     emit_kind = KIND_DATA_END;
                  end else begin
                     phase_in = PH_DATA_BODY;
                  end
               end
            end
            PH_DATA_BODY: begin
               riff_pos_in  = pos_bumped;
               data_left_in = data_left_ff - 32'd1;
               if (!partial_frame) begin
                  if (!fmt_bits_ff[4]) begin
                     have_sample = 1'b1;
                     emit_raw    = {8'd0, in_byte};
                  end else if (fbc_ff == '0) begin
                     low_in = in_byte;
                     fbc_in = 5'd1;
                  end else begin
                     have_sample = 1'b1;
                     emit_raw    = {in_byte, low_ff};
                     fbc_in      = '0;
                  end
                  if (have_sample && (fmt_ch_ff == 2'd2)) begin
                     cur_ch_in = ~cur_ch_ff;
                  end
               end
               if (have_sample) begin
                  emit      = 1'b1;
                  emit_kind = KIND_SAMPLE;
                  emit_chan = cur_ch_ff;
               end
               if (data_left_ff == 32'd1) begin
                  fbc_in    = '0;
                  cur_ch_in = 1'b0;
                  if (have_sample) begin
                     phase_in = PH_END_PENDING;
                  end else begin
                     phase_in  = PH_CHUNK_ID;
                     emit      = 1'b1;
                     emit_kind = KIND_DATA_END;
                     emit_raw  = '0;
                     emit_chan = 1'b0;
                  end
               end
            end
            PH_STOPPED: begin
            end
            default: begin
            end
         endcase
      end

      cmd_push       = emit;
      cmd.kind       = emit_kind;
      cmd.sample_raw = emit_raw;
      cmd.wide       = fmt_bits_ff[4];
      cmd.chan       = emit_chan;
      cmd.chans      = fmt_ch_in;
      cmd.rate       = fmt_rate_in;
      cmd.bits       = fmt_bits_in;
      cmd.err        = emit_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG_RIFF;
         fbc_ff       <= '0;
         asm_ff       <= '0;
         riff_len_ff  <= '0;
         riff_pos_ff  <= '0;
         fmt_ch_ff    <= '0;
         fmt_rate_ff  <= '0;
         fmt_bits_ff  <= '0;
         data_left_ff <= '0;
         cur_ch_ff    <= 1'b0;
         low_ff       <= '0;
         fmt_found_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fbc_ff       <= fbc_in;
         asm_ff       <= asm_in;
         riff_len_ff  <= riff_len_in;
         riff_pos_ff  <= riff_pos_in;
         fmt_ch_ff    <= fmt_ch_in;
         fmt_rate_ff  <= fmt_rate_in;
         fmt_bits_ff  <= fmt_bits_in;
         data_left_ff <= data_left_in;
         cur_ch_ff    <= cur_ch_in;
         low_ff       <= low_in;
         fmt_found_ff <= fmt_found_in;
      end
   end

endmodule

FILE: src/wps_back.sv
// Sample converter back end: two-stage pipeline that scales PCM samples to
// signed fixed point and packs finished results. Depends on wps_pkg.
module wps_back #(
   parameter int SAMPLE_OUT_WIDTH = wps_pkg::SAMPLE_OUT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wps_pkg::cmd_type              cmd,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   output logic [SAMPLE_OUT_WIDTH+43:0]  out_data,
   output logic                          out_push,
   input  logic                          out_full
);

   import wps_pkg::*;

   localparam int SW = SAMPLE_OUT_WIDTH;
   localparam int XW = SW + 7;   // byte scaled by half full range, plus rounding
   localparam int TW = XW + 1;
   localparam int OW = SW + 44;
   localparam int unsigned BIAS = 1 << (SW - 2);
   localparam int unsigned ROUND_HALF = 127;
   localparam int unsigned DIVISOR = 255;

   logic          s1_valid_ff, s1_valid_in;
   cmd_type       s1_cmd_ff, s1_cmd_in;
   logic [TW-1:0] s1_t_ff, s1_t_in;
   logic          s2_valid_ff, s2_valid_in;
   logic [OW-1:0] s2_data_ff, s2_data_in;

   logic          advance;
   logic [XW-1:0] x_head, x_s1;
   logic [SW-1:0] q_s1;
   logic [TW-1:0] rem_s1;
   logic          fix_s1;
   logic [SW-1:0] sample8, sample16, sample_value;

   assign advance  = !(s2_valid_ff && out_full);
   assign cmd_pop  = advance && !cmd_empty;
   assign out_push = s2_valid_ff && !out_full;
   assign out_data = s2_data_ff;

   // Stage 1: x / 255 estimated as (x + x/256 + x/2^16 + x/2^24) / 256, which is
   // exact or one short.
   always_comb begin
      x_head      = (XW'(cmd.sample_raw[7:0]) << (SW - 1)) + XW'(ROUND_HALF);
      s1_t_in     = TW'(x_head) + TW'(x_head >> 8) + TW'(x_head >> 16) + TW'(x_head >> 24);
      s1_cmd_in   = cmd;
      s1_valid_in = !cmd_empty;
   end

   // Stage 2: correct the estimate by its remainder, remove the offset and pack the result.
   always_comb begin
      x_s1     = (XW'(s1_cmd_ff.sample_raw[7:0]) << (SW - 1)) + XW'(ROUND_HALF);
      q_s1     = s1_t_ff[TW-1:8];
      rem_s1   = TW'(x_s1) - {q_s1, 8'd0} + TW'(q_s1);
      fix_s1   = (rem_s1 >= TW'(DIVISOR));
      sample8  = q_s1 + SW'(fix_s1) - SW'(BIAS);
      sample16 = SW'(s1_cmd_ff.sample_raw) << (SW - 16);
      if (s1_cmd_ff.kind == KIND_SAMPLE) begin
         sample_value = s1_cmd_ff.wide ? sample16 : sample8;
      end else begin
         sample_value = '0;
      end
      s2_data_in  = {s1_cmd_ff.kind, sample_value, s1_cmd_ff.chan, s1_cmd_ff.chans,
                     s1_cmd_ff.rate, s1_cmd_ff.bits, s1_cmd_ff.err};
      s2_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff  <= s1_cmd_in;
         s1_t_ff    <= s1_t_in;
         s2_data_ff <= s2_data_in;
      end
   end

endmodule
